[rtl/nrdmrs_pkg.sv]
// ----------------------------------------------------------------------------
// nrdmrs_pkg
// Shared types and constants of the NR DMRS / PBCH pilot generator.
// ----------------------------------------------------------------------------
package nrdmrs_pkg;

    localparam logic [8:0]  MAX_RB      = 9'd275;
    localparam logic [15:0] QPSK_AMP    = 16'd23170;
    localparam logic [10:0] PORT_DATA   = 11'd1000;
    localparam logic [10:0] PORT_END_T1 = 11'd1008;
    localparam logic [10:0] PORT_END_T2 = 11'd1012;
    localparam logic [10:0] PORT_CTRL   = 11'd2000;
    localparam logic [11:0] SL_LEN      = 12'd33;
    localparam logic [11:0] PBCH_M0_1   = 12'd60;
    localparam logic [11:0] PBCH_END_1  = 12'd84;
    localparam logic [11:0] PBCH_END_2  = 12'd144;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [2:0] {
        MODE_PUSCH   = 3'd0,
        MODE_PDSCH   = 3'd1,
        MODE_PDCCH   = 3'd2,
        MODE_PBCH    = 3'd3,
        MODE_SL_PBCH = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        REG_MODE        = 3'd0,
        REG_PILOT_TYPE  = 3'd1,
        REG_ANT_PORT    = 3'd2,
        REG_TIME_INDEX  = 3'd3,
        REG_NUM_RB      = 3'd4,
        REG_SC_START    = 3'd5,
        REG_SCALING     = 3'd6,
        REG_PBCH_SYMBOL = 3'd7
    } t_cfg_idx;

    // Pilot window and cover terms derived from the configuration.
    typedef struct packed {
        logic        valid;     // mode and port give pilots at all
        logic        nonempty;  // window length above zero
        logic        covered;   // data channel: cover and scaling apply
        logic        row_odd;   // frequency cover flips odd pilots
        logic        neg_t;     // time cover flips every pilot
        logic [11:0] m0;        // first pair position of the window
        logic [11:0] last_g;    // last pair position of the window
    } t_window;

    typedef struct packed {
        logic [31:0] word;
        logic [7:0]  wpos;
    } t_qentry;

    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_status;

endpackage

[rtl/nrdmrs_cfg.sv]
// ----------------------------------------------------------------------------
// nrdmrs_cfg
// Configuration registers, pilot window decode and the scaled amplitude.
// ----------------------------------------------------------------------------
module nrdmrs_cfg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [2:0]            i_cfg_index,
    input  logic [15:0]           i_cfg_wdata,
    output nrdmrs_pkg::t_window   o_window,
    output logic signed [31:0]    o_amp_q
);

    logic [2:0]         r_mode;
    logic               r_pilot_type;
    logic [10:0]        r_ant_port;
    logic               r_time_index;
    logic [8:0]         r_num_rb;
    logic [11:0]        r_sc_start;
    logic [15:0]        r_scaling;
    logic [3:0]         r_pbch_symbol;
    logic signed [31:0] r_amp_q;
    logic signed [31:0] n_amp_q;

    logic [8:0]  rb;
    logic [11:0] len;
    logic [10:0] port_end;
    logic [3:0]  row;
    logic [23:0] third;
    logic [11:0] sl_step;
    nrdmrs_pkg::t_window win;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= nrdmrs_pkg::MODE_PDSCH;
            r_pilot_type  <= 1'b0;
            r_ant_port    <= nrdmrs_pkg::PORT_DATA;
            r_time_index  <= 1'b0;
            r_num_rb      <= 9'd0;
            r_sc_start    <= 12'd0;
            r_scaling     <= 16'd16384;
            r_pbch_symbol <= 4'd0;
        end else if (i_cfg_wr_en) begin
            case (nrdmrs_pkg::t_cfg_idx'(i_cfg_index))
                nrdmrs_pkg::REG_MODE:        r_mode        <= i_cfg_wdata[2:0];
                nrdmrs_pkg::REG_PILOT_TYPE:  r_pilot_type  <= i_cfg_wdata[0];
                nrdmrs_pkg::REG_ANT_PORT:    r_ant_port    <= i_cfg_wdata[10:0];
                nrdmrs_pkg::REG_TIME_INDEX:  r_time_index  <= i_cfg_wdata[0];
                nrdmrs_pkg::REG_NUM_RB:      r_num_rb      <= i_cfg_wdata[8:0];
                nrdmrs_pkg::REG_SC_START:    r_sc_start    <= i_cfg_wdata[11:0];
                nrdmrs_pkg::REG_SCALING:     r_scaling     <= i_cfg_wdata;
                nrdmrs_pkg::REG_PBCH_SYMBOL: r_pbch_symbol <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // The pilot magnitude is fixed, so the product is taken once per cycle.
    always_comb begin
        n_amp_q = $signed({{16{r_scaling[15]}}, r_scaling}) *
                  $signed({16'd0, nrdmrs_pkg::QPSK_AMP});
    end

    always_ff @(posedge i_clk) begin
        r_amp_q <= n_amp_q;
    end

    always_comb begin
        rb       = (r_num_rb > nrdmrs_pkg::MAX_RB) ? nrdmrs_pkg::MAX_RB : r_num_rb;
        port_end = r_pilot_type ? nrdmrs_pkg::PORT_END_T2 : nrdmrs_pkg::PORT_END_T1;
        row      = 4'(r_ant_port - nrdmrs_pkg::PORT_DATA);
        // Divide by three through the reciprocal 2731 / 2^13, exact below 4096.
        third    = 24'(r_sc_start) * 24'd2731;
        sl_step  = 12'(r_pbch_symbol - 4'd4);
        len      = 12'd0;
        win      = '0;
        case (r_mode)
            nrdmrs_pkg::MODE_PUSCH, nrdmrs_pkg::MODE_PDSCH: begin
                win.valid   = (r_ant_port >= nrdmrs_pkg::PORT_DATA) &&
                              (r_ant_port < port_end);
                win.covered = 1'b1;
                if (r_mode == nrdmrs_pkg::MODE_PUSCH) begin
                    win.m0 = r_pilot_type ? {1'b0, third[23:13]}
                                          : {1'b0, r_sc_start[11:1]};
                end
                len = r_pilot_type ? {1'b0, rb, 2'b00}
                                   : ({1'b0, rb, 2'b00} + {2'b00, rb, 1'b0});
            end
            nrdmrs_pkg::MODE_PDCCH: begin
                win.valid = (r_ant_port == nrdmrs_pkg::PORT_CTRL);
                len       = {3'd0, rb} + {2'd0, rb, 1'b0};
            end
            nrdmrs_pkg::MODE_PBCH: begin
                win.valid = (r_pbch_symbol <= 4'd2);
                case (r_pbch_symbol)
                    4'd0: len = nrdmrs_pkg::PBCH_M0_1;
                    4'd1: begin
                        win.m0 = nrdmrs_pkg::PBCH_M0_1;
                        len    = nrdmrs_pkg::PBCH_END_1 - nrdmrs_pkg::PBCH_M0_1;
                    end
                    default: begin
                        win.m0 = nrdmrs_pkg::PBCH_END_1;
                        len    = nrdmrs_pkg::PBCH_END_2 - nrdmrs_pkg::PBCH_END_1;
                    end
                endcase
            end
            nrdmrs_pkg::MODE_SL_PBCH: begin
                len = nrdmrs_pkg::SL_LEN;
                if (r_pbch_symbol == 4'd0) begin
                    win.valid = 1'b1;
                end else begin
                    win.valid = (r_pbch_symbol >= 4'd5) && (r_pbch_symbol <= 4'd12);
                    win.m0    = (sl_step << 5) + sl_step;
                end
            end
            default: ;
        endcase
        win.nonempty = (len != 12'd0);
        win.last_g   = win.m0 + len - 12'd1;
        win.row_odd  = row[0];
        win.neg_t    = r_time_index && (row >= (r_pilot_type ? 4'd6 : 4'd4));
    end

    assign o_window = win;
    assign o_amp_q  = r_amp_q;

endmodule

[rtl/nrdmrs_front.sv]
// ----------------------------------------------------------------------------
// nrdmrs_front
// Takes gold words, tracks the word position and queues words with pilots.
// ----------------------------------------------------------------------------
module nrdmrs_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clear,
    input  nrdmrs_pkg::t_window   i_window,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,    // [31:0] gold_word
    input  nrdmrs_pkg::t_q_status i_q_status,
    output logic                  o_push,
    output nrdmrs_pkg::t_qentry   o_entry
);

    logic [7:0]  r_wpos;
    logic [7:0]  n_wpos;
    logic [11:0] base;
    logic [11:0] top;
    logic        accept;
    logic        hit;
    logic        saw_last;

    always_comb begin
        base     = {r_wpos, 4'h0};
        top      = {r_wpos, 4'hF};
        accept   = s_axis_tvalid && !i_q_status.full;
        hit      = i_window.valid && i_window.nonempty &&
                   (top >= i_window.m0) && (base <= i_window.last_g);
        // The final pilot falls in this word when the window end does.
        saw_last = i_window.valid && i_window.nonempty &&
                   (i_window.last_g[11:4] == r_wpos);
        n_wpos   = r_wpos;
        if (i_clear) begin
            n_wpos = 8'd0;
        end else if (accept) begin
            n_wpos = saw_last ? 8'd0 : r_wpos + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos <= 8'd0;
        end else begin
            r_wpos <= n_wpos;
        end
    end

    assign s_axis_tready = !i_q_status.full;
    assign o_push        = accept && hit;
    assign o_entry.word  = s_axis_tdata;
    assign o_entry.wpos  = r_wpos;

endmodule

[rtl/nrdmrs_fifo.sv]
// ----------------------------------------------------------------------------
// nrdmrs_fifo
// Short queue of gold words between the front and the back.
// ----------------------------------------------------------------------------
module nrdmrs_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  nrdmrs_pkg::t_qentry   i_entry,
    input  logic                  i_pop,
    output nrdmrs_pkg::t_qentry   o_head,
    output nrdmrs_pkg::t_q_status o_status
);

    nrdmrs_pkg::t_qentry r_slot [nrdmrs_pkg::QDEPTH];
    logic [nrdmrs_pkg::QAW-1:0] r_wr_ptr;
    logic [nrdmrs_pkg::QAW-1:0] r_rd_ptr;
    logic [nrdmrs_pkg::QAW:0]   r_count;
    logic do_push;
    logic do_pop;

    assign do_push = i_push && (r_count != (nrdmrs_pkg::QAW+1)'(nrdmrs_pkg::QDEPTH));
    assign do_pop  = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    assign o_head             = r_slot[r_rd_ptr];
    assign o_status.full      = (r_count == (nrdmrs_pkg::QAW+1)'(nrdmrs_pkg::QDEPTH));
    assign o_status.not_empty = (r_count != '0);

endmodule

[rtl/nrdmrs_back.sv]
// ----------------------------------------------------------------------------
// nrdmrs_back
// Walks a queued word's 16 bit pairs; emits one pilot per cycle unless stalled.
// ----------------------------------------------------------------------------
module nrdmrs_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  nrdmrs_pkg::t_window   i_window,
    input  logic signed [31:0]    i_amp_q,
    input  nrdmrs_pkg::t_qentry   i_head,
    input  nrdmrs_pkg::t_q_status i_q_status,
    output logic                  o_pop,
    output logic                  o_busy,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [47:0]           m_axis_tdata,  // [15:0] pilot_re, [31:16] pilot_im,
                                                 // [42:32] pilot_index, rest zero
    output logic                  m_axis_tlast
);

    logic        r_busy;
    logic [3:0]  r_j;
    logic [31:0] r_word;
    logic [7:0]  r_wpos;
    logic        r_out_valid;
    logic [15:0] r_out_re;
    logic [15:0] r_out_im;
    logic [10:0] r_out_index;
    logic        r_out_last;

    logic        step;
    logic        load;
    logic        done;
    logic        in_win;
    logic [11:0] g;
    logic [1:0]  bits;
    logic        flip;
    logic        re_neg;
    logic        im_neg;
    logic signed [31:0] neg_amp;
    logic [15:0] pos_q;
    logic [15:0] neg_q;
    logic [15:0] pilot_re;
    logic [15:0] pilot_im;
    logic [11:0] offset;

    always_comb begin
        g       = {r_wpos, r_j};
        in_win  = (g >= i_window.m0) && (g <= i_window.last_g);
        done    = (r_j == 4'hF) || (g == i_window.last_g);
        step    = r_busy && (!r_out_valid || m_axis_tready);
        load    = i_q_status.not_empty && (!r_busy || (step && done));
        bits    = r_word[{r_j, 1'b0} +: 2];
        flip    = i_window.covered && ((g[0] && i_window.row_odd) ^ i_window.neg_t);
        re_neg  = bits[0] ^ flip;
        im_neg  = !bits[1] ^ flip;
        // Floor of the Q14 product is an arithmetic shift of the wide value.
        neg_amp = -i_amp_q;
        pos_q   = i_amp_q[29:14];
        neg_q   = neg_amp[29:14];
        if (i_window.covered) begin
            pilot_re = re_neg ? neg_q : pos_q;
            pilot_im = im_neg ? neg_q : pos_q;
        end else begin
            pilot_re = re_neg ? -nrdmrs_pkg::QPSK_AMP : nrdmrs_pkg::QPSK_AMP;
            pilot_im = im_neg ? -nrdmrs_pkg::QPSK_AMP : nrdmrs_pkg::QPSK_AMP;
        end
        offset = g - i_window.m0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_j         <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_j    <= 4'd0;
            end else if (step) begin
                r_busy <= !done;
                r_j    <= r_j + 4'd1;
            end
            if (step) begin
                r_out_valid <= in_win;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word <= i_head.word;
            r_wpos <= i_head.wpos;
        end
        if (step && in_win) begin
            r_out_re    <= pilot_re;
            r_out_im    <= pilot_im;
            r_out_index <= offset[10:0];
            r_out_last  <= (g == i_window.last_g);
        end
    end

    assign o_pop         = load;
    assign o_busy        = r_busy;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_index, r_out_im, r_out_re};
    assign m_axis_tlast  = r_out_last;

endmodule

[rtl/nr_dmrs_pilot_generator.sv]
// ----------------------------------------------------------------------------
// nr_dmrs_pilot_generator
// Conjugated QPSK pilot generator for NR DMRS, PDCCH and PBCH reception.
// ----------------------------------------------------------------------------
// Usage: program the eight registers through the write port while the block
// is idle; any write also restarts the word count. Gold-sequence words then
// enter on the s_axis channel, one 32-bit word per request, each holding
// sixteen bit pairs with the lowest pair first. For every pair whose position
// lies inside the window chosen by the mode, one pilot leaves on the m_axis
// channel: real part in the low half-word, imaginary part above it, and the
// pilot's index within the window above that. tlast marks the final pilot of
// the window, after which the word count starts again from zero.
// Timing: the front takes a word in any cycle in which its four-entry queue
// has room. The back walks the pairs of a queued word one per cycle while
// the receiver keeps tready high; a word is queued, loaded into the walker,
// and its pilots leave through the output register. Throughput is one pilot
// per cycle while tready stays high, set by the single pair walker in the
// back. Words without any pilot are counted but never queued.
// Reset restores the register defaults and empties the queue and output
// register. When the receiver holds tready low, the output register keeps
// its pilot, the walker stops, and once the queue fills s_axis_tready drops.
// ----------------------------------------------------------------------------
module nr_dmrs_pilot_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    // Gold-sequence words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] gold_word
    // Pilots
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [15:0] pilot_re, [31:16] pilot_im,
                                        // [42:32] pilot_index, [47:43] zero
    output logic        m_axis_tlast
);

    nrdmrs_pkg::t_window   window;
    nrdmrs_pkg::t_qentry   q_in;
    nrdmrs_pkg::t_qentry   q_head;
    nrdmrs_pkg::t_q_status q_status;
    logic signed [31:0]    amp_q;
    logic                  q_push;
    logic                  q_pop;
    logic                  back_busy;

    nrdmrs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_window    (window),
        .o_amp_q     (amp_q)
    );

    // The front classifies each word against the window and keeps the count.
    nrdmrs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_clear       (i_cfg_wr_en),
        .i_window      (window),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_q_status    (q_status),
        .o_push        (q_push),
        .o_entry       (q_in)
    );

    nrdmrs_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_entry  (q_in),
        .i_pop    (q_pop),
        .o_head   (q_head),
        .o_status (q_status)
    );

    // The back turns queued words into pilots behind an output register.
    nrdmrs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_window      (window),
        .i_amp_q       (amp_q),
        .i_head        (q_head),
        .i_q_status    (q_status),
        .o_pop         (q_pop),
        .o_busy        (back_busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // A full queue can never be reported as empty.
    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.full |-> q_status.not_empty)
        else $error("queue full while empty");

    // The back only takes a word that the queue actually holds.
    a_pop_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_status.not_empty)
        else $error("word taken from an empty queue");

    // A new pilot appears only after the walker was busy on a word.
    a_pilot_from_walker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(back_busy))
        else $error("pilot appeared without a word in progress");

endmodule

[bench/tb_nr_dmrs_pilot_generator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nr_dmrs_pilot_generator
// Self-checking bench for the conjugated QPSK pilot generator. Gold words go
// in on the slave stream and pilots come out on the master stream. A
// scoreboard works out the pilots that each accepted word should produce and
// compares every pilot that leaves the block, field by field.
// ----------------------------------------------------------------------------
module tb_nr_dmrs_pilot_generator;

    localparam int          WORD_TARGET  = 410;     // stimulus stops here
    localparam int          IDLE_PERCENT = 29;      // chance of a gap per cycle
    localparam int          SETTLE_CYCLES = 40;     // queue drain margin
    localparam int          CYCLE_LIMIT  = 400000;  // many times the slowest run
    localparam logic [2:0]  MODE_SPARE   = 3'd7;    // highest unused mode code

    // Register set of the block, one field per configuration register.
    typedef struct {
        logic [2:0]         mode;
        logic               pilot_type;
        logic [10:0]        port;
        logic               time_index;
        logic [8:0]         num_rb;
        logic [11:0]        sc_start;
        logic signed [15:0] scaling;
        logic [3:0]         pbch_symbol;
    } t_dmrs_cfg;

    // One pilot as it should leave the block.
    typedef struct {
        logic [15:0] re;
        logic [15:0] im;
        logic [10:0] index;
        logic        last;
    } t_pilot_rec;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the registers and of the word count,
    // predicts the pilots of each accepted word and checks what arrives.
    // ------------------------------------------------------------------------
    class pilot_scoreboard;
        t_dmrs_cfg   cfg;
        logic [7:0]  word_pos;
        t_pilot_rec  due_pilots[$];
        int unsigned errors;

        function new();
            cfg.mode        = nrdmrs_pkg::MODE_PDSCH;
            cfg.pilot_type  = 1'b0;
            cfg.port        = nrdmrs_pkg::PORT_DATA;
            cfg.time_index  = 1'b0;
            cfg.num_rb      = '0;
            cfg.sc_start    = '0;
            cfg.scaling     = 16'sh4000;
            cfg.pbch_symbol = '0;
            word_pos        = '0;
            errors          = 0;
        endfunction

        // Pilot window selected by a register set; false means no pilots at all.
        function bit window_of(input t_dmrs_cfg c, output int m0, output int len,
                               output bit covered);
            int rb;
            rb      = (c.num_rb > nrdmrs_pkg::MAX_RB) ? int'(nrdmrs_pkg::MAX_RB)
                                                      : int'(c.num_rb);
            m0      = 0;
            len     = 0;
            covered = 1'b0;
            case (c.mode)
                nrdmrs_pkg::MODE_PUSCH, nrdmrs_pkg::MODE_PDSCH: begin
                    if (c.port < nrdmrs_pkg::PORT_DATA ||
                        c.port >= (c.pilot_type ? nrdmrs_pkg::PORT_END_T2
                                                : nrdmrs_pkg::PORT_END_T1))
                        return 1'b0;
                    if (c.mode == nrdmrs_pkg::MODE_PUSCH)
                        m0 = int'(c.sc_start) / (c.pilot_type ? 3 : 2);
                    len     = rb * (c.pilot_type ? 4 : 6);
                    covered = 1'b1;
                    return 1'b1;
                end
                nrdmrs_pkg::MODE_PDCCH: begin
                    if (c.port != nrdmrs_pkg::PORT_CTRL)
                        return 1'b0;
                    len = rb * 3;
                    return 1'b1;
                end
                nrdmrs_pkg::MODE_PBCH: begin
                    case (c.pbch_symbol)
                        4'd0: len = int'(nrdmrs_pkg::PBCH_M0_1);
                        4'd1: begin
                            m0  = int'(nrdmrs_pkg::PBCH_M0_1);
                            len = int'(nrdmrs_pkg::PBCH_END_1) -
                                  int'(nrdmrs_pkg::PBCH_M0_1);
                        end
                        4'd2: begin
                            m0  = int'(nrdmrs_pkg::PBCH_END_1);
                            len = int'(nrdmrs_pkg::PBCH_END_2) -
                                  int'(nrdmrs_pkg::PBCH_END_1);
                        end
                        default: return 1'b0;
                    endcase
                    return 1'b1;
                end
                nrdmrs_pkg::MODE_SL_PBCH: begin
                    if (c.pbch_symbol == 4'd0) begin
                        len = int'(nrdmrs_pkg::SL_LEN);
                    end else if (c.pbch_symbol >= 4'd5 && c.pbch_symbol <= 4'd12) begin
                        m0  = (int'(c.pbch_symbol) - 4) * int'(nrdmrs_pkg::SL_LEN);
                        len = int'(nrdmrs_pkg::SL_LEN);
                    end else begin
                        return 1'b0;
                    end
                    return 1'b1;
                end
                default: return 1'b0;
            endcase
        endfunction

        // Any register write restarts the word count.
        function void reg_written(input nrdmrs_pkg::t_cfg_idx idx, input logic [15:0] v);
            case (idx)
                nrdmrs_pkg::REG_MODE:        cfg.mode        = v[2:0];
                nrdmrs_pkg::REG_PILOT_TYPE:  cfg.pilot_type  = v[0];
                nrdmrs_pkg::REG_ANT_PORT:    cfg.port        = v[10:0];
                nrdmrs_pkg::REG_TIME_INDEX:  cfg.time_index  = v[0];
                nrdmrs_pkg::REG_NUM_RB:      cfg.num_rb      = v[8:0];
                nrdmrs_pkg::REG_SC_START:    cfg.sc_start    = v[11:0];
                nrdmrs_pkg::REG_SCALING:     cfg.scaling     = v;
                nrdmrs_pkg::REG_PBCH_SYMBOL: cfg.pbch_symbol = v[3:0];
                default: ;
            endcase
            word_pos = '0;
        endfunction

        // Works out the pilots of one accepted gold word.
        function void predict_pilots(input logic [31:0] w);
            int         m0, len, g, re, im, row, t_limit, amp, scl;
            bit         covered, ok, neg_f, neg_t, hit_end;
            t_pilot_rec p;
            ok      = window_of(cfg, m0, len, covered);
            row     = int'(cfg.port) - int'(nrdmrs_pkg::PORT_DATA);
            t_limit = cfg.pilot_type ? 6 : 4;
            amp     = int'(nrdmrs_pkg::QPSK_AMP);
            scl     = int'(cfg.scaling);
            hit_end = 1'b0;
            for (int j = 0; j < 16 && ok; j++) begin
                g = int'(word_pos) * 16 + j;
                if (g < m0 || g >= m0 + len)
                    continue;
                // Conjugated QPSK: the lower bit sets the real sign, the upper
                // bit the imaginary sign with the opposite sense.
                re = w[2*j]   ? -amp : amp;
                im = w[2*j+1] ? amp : -amp;
                if (covered) begin
                    neg_f = g[0] && row[0];
                    neg_t = cfg.time_index && (row >= t_limit);
                    if (neg_f != neg_t) begin
                        re = -re;
                        im = -im;
                    end
                    // Q14 product rounded towards minus infinity.
                    re = (re * scl) >>> 14;
                    im = (im * scl) >>> 14;
                end
                p.re    = re[15:0];
                p.im    = im[15:0];
                p.index = 11'(g - m0);
                p.last  = (g == m0 + len - 1);
                if (p.last)
                    hit_end = 1'b1;
                due_pilots.push_back(p);
            end
            word_pos = hit_end ? 8'd0 : word_pos + 8'd1;
        endfunction

        function void check_pilot(input logic [47:0] d, input logic l);
            t_pilot_rec e;
            if (due_pilots.size() == 0) begin
                $error("pilot with none expected: tdata %h, tlast %b", d, l);
                errors++;
                return;
            end
            e = due_pilots.pop_front();
            if (d[15:0] !== e.re) begin
                $error("pilot_re: expected %0d, actual %0d", $signed(e.re), $signed(d[15:0]));
                errors++;
            end
            if (d[31:16] !== e.im) begin
                $error("pilot_im: expected %0d, actual %0d", $signed(e.im), $signed(d[31:16]));
                errors++;
            end
            if (d[42:32] !== e.index) begin
                $error("pilot_index: expected %0d, actual %0d", e.index, d[42:32]);
                errors++;
            end
            if (l !== e.last) begin
                $error("last: expected %0b, actual %0b", e.last, l);
                errors++;
            end
        endfunction

        function int pending();
            return due_pilots.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block under test. Every input has a known value from
    // time zero.
    // ------------------------------------------------------------------------
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_wr_en   = 1'b0;
    nrdmrs_pkg::t_cfg_idx i_cfg_index   = nrdmrs_pkg::REG_MODE;
    logic [15:0]          i_cfg_wdata   = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [47:0]          m_axis_tdata;
    logic                 m_axis_tlast;

    pilot_scoreboard sb;
    int              words_sent = 0;
    int              cycles     = 0;
    bit              quiet      = 1'b0;   // no gaps on either side while set

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    nr_dmrs_pilot_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Pilot receiver. Values read just after the edge are those from before
    // it, so a pilot is taken exactly when both tvalid and tready were high.
    // tready is then redrawn for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_pilot(m_axis_tdata, m_axis_tlast);
            m_axis_tready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers. A task never lowers a signal it is about to raise again in the
    // same step: tvalid stays high from one request to the next unless a gap
    // is drawn, and the write enable is lowered only after the last write.
    // ------------------------------------------------------------------------
    task automatic write_reg(input nrdmrs_pkg::t_cfg_idx idx, input logic [15:0] v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        sb.reg_written(idx, v);
    endtask

    task automatic apply_cfg(input t_dmrs_cfg c);
        write_reg(nrdmrs_pkg::REG_MODE,        16'(c.mode));
        write_reg(nrdmrs_pkg::REG_PILOT_TYPE,  16'(c.pilot_type));
        write_reg(nrdmrs_pkg::REG_ANT_PORT,    16'(c.port));
        write_reg(nrdmrs_pkg::REG_TIME_INDEX,  16'(c.time_index));
        write_reg(nrdmrs_pkg::REG_NUM_RB,      16'(c.num_rb));
        write_reg(nrdmrs_pkg::REG_SC_START,    16'(c.sc_start));
        write_reg(nrdmrs_pkg::REG_SCALING,     c.scaling);
        write_reg(nrdmrs_pkg::REG_PBCH_SYMBOL, 16'(c.pbch_symbol));
        i_cfg_wr_en <= 1'b0;
    endtask

    // Offers one gold word and returns in the step in which it was accepted.
    task automatic send_word(input logic [31:0] w);
        quiet = (words_sent >= 150 && words_sent < 240);
        while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.predict_pilots(w);
        words_sent++;
    endtask

    task automatic send_random_words(input int n);
        repeat (n) send_word($urandom);
    endtask

    // Stops offering words and lets the block drain before any register write.
    // Words outside the window produce nothing, so a margin follows the last
    // expected pilot as well.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_dmrs_cfg make_cfg(input logic [2:0] mode, input logic typ,
                                           input logic [10:0] port, input logic ti,
                                           input logic [8:0] rb, input logic [11:0] sc,
                                           input logic [15:0] scl, input logic [3:0] sym);
        t_dmrs_cfg c;
        c.mode        = mode;
        c.pilot_type  = typ;
        c.port        = port;
        c.time_index  = ti;
        c.num_rb      = rb;
        c.sc_start    = sc;
        c.scaling     = scl;
        c.pbch_symbol = sym;
        return c;
    endfunction

    // Mostly well-formed settings with small allocations; now and then an
    // unused mode, a stray port, a stray symbol or a large allocation.
    function automatic t_dmrs_cfg rand_cfg();
        t_dmrs_cfg c;
        int        port_span;
        if ($urandom_range(19) == 0)
            c.mode = 3'($urandom_range(int'(MODE_SPARE),
                                       int'(nrdmrs_pkg::MODE_SL_PBCH) + 1));
        else
            c.mode = 3'($urandom_range(int'(nrdmrs_pkg::MODE_SL_PBCH),
                                       int'(nrdmrs_pkg::MODE_PUSCH)));
        c.pilot_type = 1'($urandom_range(1));
        port_span    = int'(c.pilot_type ? nrdmrs_pkg::PORT_END_T2 : nrdmrs_pkg::PORT_END_T1)
                       - int'(nrdmrs_pkg::PORT_DATA) - 1;
        if ($urandom_range(9) == 0)
            c.port = 11'($urandom_range(2047));
        else if (c.mode == nrdmrs_pkg::MODE_PDCCH)
            c.port = nrdmrs_pkg::PORT_CTRL;
        else
            c.port = nrdmrs_pkg::PORT_DATA + 11'($urandom_range(port_span));
        c.time_index = 1'($urandom_range(1));
        c.num_rb     = ($urandom_range(19) == 0) ? 9'($urandom_range(511))
                                                 : 9'($urandom_range(6));
        c.sc_start   = ($urandom_range(19) == 0) ? 12'($urandom_range(4095))
                                                 : 12'($urandom_range(100));
        c.scaling    = ($urandom_range(3) == 0) ? 16'sh4000 : 16'($urandom);
        if ($urandom_range(5) == 0)
            c.pbch_symbol = 4'($urandom_range(15));
        else if (c.mode == nrdmrs_pkg::MODE_SL_PBCH)
            c.pbch_symbol = ($urandom_range(3) == 0) ? 4'd0 : 4'($urandom_range(12, 5));
        else
            c.pbch_symbol = 4'($urandom_range(2));
        return c;
    endfunction

    // Number of words that carry the count up to the last pilot of the window.
    function automatic int words_to_window_end(input t_dmrs_cfg c);
        int m0, len;
        bit covered;
        if (!sb.window_of(c, m0, len, covered) || len == 0)
            return 0;
        return (m0 + len + 15) / 16;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        t_dmrs_cfg c;
        int        span, n;
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values: PDSCH with an empty allocation, so nothing comes out.
        send_word(32'h0000_0000);
        settle();
        // One resource block on the reset settings otherwise.
        write_reg(nrdmrs_pkg::REG_NUM_RB, 16'd1);
        i_cfg_wr_en <= 1'b0;
        send_word(32'hFFFF_FFFF);
        settle();
        // PUSCH type 2 on the top port with time cover and the most negative
        // scaling, which wraps the product.
        apply_cfg(make_cfg(nrdmrs_pkg::MODE_PUSCH, 1'b1, nrdmrs_pkg::PORT_END_T2 - 11'd1,
                           1'b1, 9'd1, 12'd30, 16'h8000, 4'd0));
        send_word(32'hAAAA_AAAA);
        settle();
        apply_cfg(make_cfg(nrdmrs_pkg::MODE_PDCCH, 1'b0, nrdmrs_pkg::PORT_CTRL, 1'b0,
                           9'd2, 12'd0, 16'h4000, 4'd0));
        send_word(32'h5555_5555);
        settle();
        // PDCCH on a data port: no pilots.
        apply_cfg(make_cfg(nrdmrs_pkg::MODE_PDCCH, 1'b0, nrdmrs_pkg::PORT_DATA, 1'b0,
                           9'd2, 12'd0, 16'h4000, 4'd0));
        send_random_words(1);
        settle();
        // PBCH middle symbol, window well past the first word.
        apply_cfg(make_cfg(nrdmrs_pkg::MODE_PBCH, 1'b0, nrdmrs_pkg::PORT_DATA, 1'b0,
                           9'd0, 12'd0, 16'h4000, 4'd1));
        send_random_words(6);
        settle();
        // PBCH symbol out of range.
        apply_cfg(make_cfg(nrdmrs_pkg::MODE_PBCH, 1'b0, nrdmrs_pkg::PORT_DATA, 1'b0,
                           9'd0, 12'd0, 16'h4000, 4'd3));
        send_random_words(1);
        settle();
        apply_cfg(make_cfg(nrdmrs_pkg::MODE_SL_PBCH, 1'b0, nrdmrs_pkg::PORT_DATA, 1'b0,
                           9'd0, 12'd0, 16'h4000, 4'd0));
        send_random_words(3);
        settle();
        // Sidelink symbol that has no window.
        apply_cfg(make_cfg(nrdmrs_pkg::MODE_SL_PBCH, 1'b0, nrdmrs_pkg::PORT_DATA, 1'b0,
                           9'd0, 12'd0, 16'h4000, 4'd4));
        send_random_words(1);
        settle();
        // Unused mode code.
        apply_cfg(make_cfg(MODE_SPARE, 1'b0, nrdmrs_pkg::PORT_DATA, 1'b0,
                           9'd1, 12'd0, 16'h4000, 4'd0));
        send_random_words(1);
        settle();
        // Type 1 port just past its range.
        apply_cfg(make_cfg(nrdmrs_pkg::MODE_PUSCH, 1'b0, nrdmrs_pkg::PORT_END_T1, 1'b0,
                           9'd1, 12'd0, 16'h4000, 4'd0));
        send_random_words(1);
        settle();
        // PDSCH type 2 with the largest positive scaling and time cover.
        apply_cfg(make_cfg(nrdmrs_pkg::MODE_PDSCH, 1'b1, nrdmrs_pkg::PORT_END_T1 - 11'd1,
                           1'b1, 9'd1, 12'd0, 16'h7FFF, 4'd0));
        send_random_words(1);
        settle();
        // PUSCH type 1 odd port: frequency cover on odd pilots, tiny scaling.
        apply_cfg(make_cfg(nrdmrs_pkg::MODE_PUSCH, 1'b0, nrdmrs_pkg::PORT_DATA + 11'd1,
                           1'b0, 9'd2, 12'd9, 16'h0001, 4'd0));
        send_random_words(1);
        settle();

        // Oversized control allocation, saturated to the largest size.
        apply_cfg(make_cfg(nrdmrs_pkg::MODE_PDCCH, 1'b0, nrdmrs_pkg::PORT_CTRL, 1'b0,
                           9'd511, 12'd0, 16'h4000, 4'd0));
        send_random_words(words_to_window_end(sb.cfg));
        settle();
        // Furthest start subcarrier: the window lies deep in the sequence.
        apply_cfg(make_cfg(nrdmrs_pkg::MODE_PUSCH, 1'b1, nrdmrs_pkg::PORT_DATA + 11'd6,
                           1'b1, 9'd1, 12'd4095, 16'hC000, 4'd0));
        send_random_words(words_to_window_end(sb.cfg));
        settle();

        // Random phases: most run whole windows, some repeat the window, the
        // rest stop part way or feed words that fall outside any window. The
        // last phase is cut short so that the word total stays on target.
        while (words_sent < WORD_TARGET) begin
            c    = rand_cfg();
            span = words_to_window_end(c);
            if (span == 0)
                n = $urandom_range(4, 1);
            else if ($urandom_range(7) == 0)
                n = $urandom_range(span, 1);
            else if (span <= 20 && $urandom_range(2) == 0)
                n = span * 2;
            else
                n = span;
            if (n > WORD_TARGET - words_sent)
                n = WORD_TARGET - words_sent;
            apply_cfg(c);
            send_random_words(n);
            settle();
        end

        quiet = 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
